// ===== src/swfp_pkg.sv =====
`timescale 1ns / 1ps

package swfp_pkg;

  localparam logic [12:0] MAX_FIELD_BYTES = 13'd4096;
  localparam int unsigned MAX_RESULTS = 4;

  localparam logic [2:0] REG_TERM_SET_0 = 3'd0;
  localparam logic [2:0] REG_TERM_SET_1 = 3'd1;
  localparam logic [2:0] REG_TERM_SET_2 = 3'd2;
  localparam logic [2:0] REG_TERM_SET_3 = 3'd3;
  localparam logic [2:0] REG_MAX_FIELD_LEN = 3'd4;

  localparam logic [63:0] TERM_SET_0_RESET = 64'd38654705664;
  localparam logic [12:0] MAX_FIELD_LEN_RESET = 13'd4096;

  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BQUOTE = 8'h60;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    M_LEAD = 3'd0,
    M_WORD = 3'd1,
    M_DQ = 3'd2,
    M_DQ_BS = 3'd3,
    M_SQ = 3'd4,
    M_ESC = 3'd5,
    M_TRAIL = 3'd6
  } mode_t;

  typedef struct packed {
    kind_t kind;
    logic [7:0] out_byte;
    logic [12:0] field_length;
    logic [7:0] terminator;
    logic last;
  } res_t;

  typedef struct packed {
    res_t [MAX_RESULTS-1:0] res;
    logic [2:0] cnt;
  } bundle_t;

  typedef struct packed {
    logic [255:0] term_set;
    logic [12:0] cap;
  } cfg_t;

endpackage

// ===== src/swfp_cfg_regs.sv =====
`timescale 1ns / 1ps

module swfp_cfg_regs (
  input logic clk,
  input logic rst,
  input logic cfg_we,
  input logic [2:0] cfg_index,
  input logic [63:0] cfg_data,
  output swfp_pkg::cfg_t cfg
);
  import swfp_pkg::*;

  logic [63:0] term_set_0;
  logic [63:0] term_set_1;
  logic [63:0] term_set_2;
  logic [63:0] term_set_3;
  logic [12:0] max_field_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      term_set_0 <= TERM_SET_0_RESET;
      term_set_1 <= '0;
      term_set_2 <= '0;
      term_set_3 <= '0;
      max_field_len <= MAX_FIELD_LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TERM_SET_0: term_set_0 <= cfg_data;
        REG_TERM_SET_1: term_set_1 <= cfg_data;
        REG_TERM_SET_2: term_set_2 <= cfg_data;
        REG_TERM_SET_3: term_set_3 <= cfg_data;
        REG_MAX_FIELD_LEN: max_field_len <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  assign cfg.term_set = {term_set_3, term_set_2, term_set_1, term_set_0};
  assign cfg.cap = (max_field_len > MAX_FIELD_BYTES) ? MAX_FIELD_BYTES : max_field_len;

endmodule

// ===== src/swfp_parser.sv =====
`timescale 1ns / 1ps

module swfp_parser (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  output logic s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic s_axis_tlast,
  input swfp_pkg::cfg_t cfg,
  input logic load_ready,
  output logic bundle_valid,
  output swfp_pkg::bundle_t bundle
);
  import swfp_pkg::*;

  typedef struct packed {
    mode_t mode;
    logic [12:0] count;
    bundle_t bun;
  } step_t;

  logic in_valid;
  logic [7:0] in_byte;
  logic in_eol;
  mode_t mode;
  logic [12:0] count;
  step_t step;
  logic advance;

  function automatic logic is_white(input logic [7:0] b);
    return b inside {8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};
  endfunction

  function automatic logic is_term(input logic [255:0] ts, input logic [7:0] b);
    return ts[b] && (b != CH_DQUOTE);
  endfunction

  function automatic logic dq_escapable(input logic [7:0] b);
    return b inside {CH_DQUOTE, CH_DOLLAR, CH_BSLASH, CH_BQUOTE};
  endfunction

  function automatic void push(inout step_t s, input kind_t k, input logic [7:0] b,
                               input logic [12:0] len, input logic [7:0] t);
    if (s.bun.cnt < 3'(MAX_RESULTS)) begin
      s.bun.res[s.bun.cnt[1:0]] = '{kind: k, out_byte: b, field_length: len,
                                    terminator: t, last: 1'b0};
      s.bun.cnt = s.bun.cnt + 3'd1;
    end
  endfunction

  function automatic void store(inout step_t s, input logic [12:0] cap,
                                input logic [7:0] b);
    if (s.count < cap) begin
      s.count = s.count + 13'd1;
      push(s, KIND_BYTE, b, 13'd0, 8'd0);
    end
  endfunction

  function automatic void end_field(inout step_t s, input logic [7:0] t);
    push(s, KIND_END, 8'd0, s.count, t);
    s.count = '0;
  endfunction

  function automatic void word_byte(inout step_t s, input cfg_t c, input logic [7:0] b);
    if (is_term(c.term_set, b) && !is_white(b)) begin
      end_field(s, b);
      s.mode = M_LEAD;
    end else if (is_white(b)) begin
      s.mode = M_TRAIL;
    end else if (b == CH_DQUOTE) begin
      s.mode = M_DQ;
    end else if (b == CH_SQUOTE) begin
      s.mode = M_SQ;
    end else if (b == CH_BSLASH) begin
      s.mode = M_ESC;
    end else begin
      store(s, c.cap, b);
      s.mode = M_WORD;
    end
  endfunction

  always_comb begin
    step_t s;
    s = '0;
    s.mode = mode;
    s.count = count;
    case (mode)
      M_WORD: word_byte(s, cfg, in_byte);
      M_DQ: begin
        if (in_byte == CH_BSLASH) s.mode = M_DQ_BS;
        else if (in_byte == CH_DQUOTE) s.mode = M_WORD;
        else store(s, cfg.cap, in_byte);
      end
      M_DQ_BS: begin
        if (!dq_escapable(in_byte)) store(s, cfg.cap, CH_BSLASH);
        store(s, cfg.cap, in_byte);
        s.mode = M_DQ;
      end
      M_SQ: begin
        if (in_byte == CH_SQUOTE) s.mode = M_WORD;
        else store(s, cfg.cap, in_byte);
      end
      M_ESC: begin
        store(s, cfg.cap, in_byte);
        s.mode = M_WORD;
      end
      M_TRAIL: begin
        if (!is_white(in_byte)) begin
          if (is_term(cfg.term_set, in_byte)) begin
            end_field(s, in_byte);
            s.mode = M_LEAD;
          end else begin
            end_field(s, CH_SPACE);
            word_byte(s, cfg, in_byte);
          end
        end
      end
      default: begin
        s.mode = M_LEAD;
        if (!is_white(in_byte)) word_byte(s, cfg, in_byte);
      end
    endcase
    if (in_eol) begin
      if (s.mode == M_DQ_BS || s.mode == M_ESC) store(s, cfg.cap, CH_BSLASH);
      if (s.mode != M_LEAD) end_field(s, CH_SPACE);
      else if (s.bun.cnt == 3'd0) push(s, KIND_EMPTY, 8'd0, 13'd0, 8'd0);
      s.mode = M_LEAD;
      s.count = '0;
    end
    for (int i = 0; i < MAX_RESULTS; i++) begin
      s.bun.res[i].last = (3'(i + 1) == s.bun.cnt);
    end
    step = s;
  end

  assign advance = in_valid && ((step.bun.cnt == 3'd0) || load_ready);
  assign s_axis_tready = !rst && (!in_valid || advance);
  assign bundle_valid = in_valid && (step.bun.cnt != 3'd0);
  assign bundle = step.bun;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      mode <= M_LEAD;
      count <= '0;
    end else begin
      if (s_axis_tready) in_valid <= s_axis_tvalid;
      if (advance) begin
        mode <= step.mode;
        count <= step.count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_eol <= s_axis_tlast;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    advance && in_eol |=> mode == M_LEAD && count == 13'd0)
    else $error("parser state not cleared after end of line");

endmodule

// ===== src/swfp_out_buf.sv =====
`timescale 1ns / 1ps

module swfp_out_buf (
  input logic clk,
  input logic rst,
  input logic bundle_valid,
  input swfp_pkg::bundle_t bundle,
  output logic load_ready,
  output logic m_axis_tvalid,
  input logic m_axis_tready,
  output logic [31:0] m_axis_tdata,
  output logic [1:0] m_axis_tuser,
  output logic m_axis_tlast
);
  import swfp_pkg::*;

  logic busy;
  logic [1:0] idx;
  bundle_t held;
  res_t cur;
  logic last_beat;

  assign cur = held.res[idx];
  assign last_beat = ({1'b0, idx} == (held.cnt - 3'd1));
  assign load_ready = !busy || (m_axis_tready && last_beat);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx <= '0;
    end else if (bundle_valid && load_ready) begin
      busy <= 1'b1;
      idx <= '0;
    end else if (busy && m_axis_tready) begin
      if (last_beat) busy <= 1'b0;
      else idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (bundle_valid && load_ready) held <= bundle;
  end

  assign m_axis_tvalid = busy;
  assign m_axis_tdata = {3'b000, cur.terminator, cur.field_length, cur.out_byte};
  assign m_axis_tuser = cur.kind;
  assign m_axis_tlast = cur.last;

  assert property (@(posedge clk) disable iff (rst)
    busy |-> ({1'b0, idx} < held.cnt))
    else $error("result index beyond held count");

  assert property (@(posedge clk) disable iff (rst)
    busy && !m_axis_tready |=> busy && $stable(idx))
    else $error("result index moved while stalled");

  assert property (@(posedge clk) disable iff (rst)
    busy |-> (m_axis_tlast == last_beat))
    else $error("last flag disagrees with result count");

endmodule

// ===== src/shell_word_field_parser_unit.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Signals                        Contents
// s_axis    in         tvalid tready tdata tlast      tdata[7:0] in_byte, tlast end_of_line
// m_axis    out        tvalid tready tdata tuser tlast tdata: out_byte, field_length,
//                                                     terminator; tuser kind; tlast last
// cfg       in         cfg_we cfg_index cfg_data      register write, no read-back
//
// One byte is accepted per cycle while each byte gives at most one result and
// the output is ready. A byte that gives several results occupies the output
// register until its last result is taken, which sets the rate; the input register takes the next byte meanwhile.
// An accepted byte passes the input register and then the output register before its first result appears.
// Reset is synchronous; the input is held off during reset and is ready in
// the first cycle after reset falls.

module shell_word_field_parser_unit (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  output logic s_axis_tready,
  input logic [7:0] s_axis_tdata,  // [7:0] in_byte
  input logic s_axis_tlast,
  output logic m_axis_tvalid,
  input logic m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [7:0] out_byte, [20:8] field_length,
                                     // [28:21] terminator, [31:29] zero
  output logic [1:0] m_axis_tuser,   // [1:0] kind
  output logic m_axis_tlast,
  input logic cfg_we,
  input logic [2:0] cfg_index,
  input logic [63:0] cfg_data
);
  import swfp_pkg::*;

  cfg_t cfg;
  bundle_t bundle;
  logic bundle_valid;
  logic load_ready;

  swfp_cfg_regs u_cfg (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cfg(cfg)
  );

  swfp_parser u_parser (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .cfg(cfg),
    .load_ready(load_ready),
    .bundle_valid(bundle_valid),
    .bundle(bundle)
  );

  swfp_out_buf u_out (
    .clk(clk),
    .rst(rst),
    .bundle_valid(bundle_valid),
    .bundle(bundle),
    .load_ready(load_ready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import swfp_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic eol;
  } line_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  shell_word_field_parser_unit u_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [255:0] term_bits = {192'd0, TERM_SET_0_RESET};
  logic [12:0] cap_reg = MAX_FIELD_LEN_RESET;
  mode_t pmode = M_LEAD;
  logic [12:0] fcount = '0;
  res_t step_res [MAX_RESULTS];
  int step_n;

  res_t token_q[$];
  line_item_t line_q[$];
  logic [7:0] line_buf[$];
  int pushed = 0;
  int n_in = 0;
  int n_out = 0;
  int fault_cnt = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  line_item_t next_item;
  res_t want;
  logic send_calm;
  logic recv_calm;

  assign send_calm = (n_in >= 180) && (n_in < 260);
  assign recv_calm = (n_out >= 200) && (n_out < 330);

  function automatic logic is_ws(input logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0a || b == 8'h0b || b == 8'h0c || b == 8'h0d;
  endfunction

  function automatic logic is_term(input logic [7:0] b);
    return term_bits[b] && b != CH_DQUOTE;
  endfunction

  function automatic void add_token(input kind_t k, input logic [7:0] b,
                                    input logic [12:0] len, input logic [7:0] t);
    if (step_n < MAX_RESULTS) begin
      step_res[step_n].kind = k;
      step_res[step_n].out_byte = b;
      step_res[step_n].field_length = len;
      step_res[step_n].terminator = t;
      step_res[step_n].last = 1'b0;
      step_n++;
    end
  endfunction

  function automatic void keep_byte(input logic [7:0] b);
    logic [12:0] lim;
    lim = (cap_reg > MAX_FIELD_BYTES) ? MAX_FIELD_BYTES : cap_reg;
    if (fcount < lim) begin
      fcount = fcount + 13'd1;
      add_token(KIND_BYTE, b, '0, '0);
    end
  endfunction

  function automatic void close_field(input logic [7:0] t);
    add_token(KIND_END, '0, fcount, t);
    fcount = '0;
  endfunction

  function automatic void word_char(input logic [7:0] b);
    if (is_term(b) && !is_ws(b)) begin
      close_field(b);
      pmode = M_LEAD;
    end else if (is_ws(b)) begin
      pmode = M_TRAIL;
    end else if (b == CH_DQUOTE) begin
      pmode = M_DQ;
    end else if (b == CH_SQUOTE) begin
      pmode = M_SQ;
    end else if (b == CH_BSLASH) begin
      pmode = M_ESC;
    end else begin
      keep_byte(b);
      pmode = M_WORD;
    end
  endfunction

  function automatic void split_byte(input logic [7:0] b, input logic eol);
    res_t r;
    step_n = 0;
    case (pmode)
      M_WORD: word_char(b);
      M_DQ: begin
        if (b == CH_BSLASH) pmode = M_DQ_BS;
        else if (b == CH_DQUOTE) pmode = M_WORD;
        else keep_byte(b);
      end
      M_DQ_BS: begin
        if (!(b == CH_DQUOTE || b == CH_DOLLAR || b == CH_BSLASH || b == CH_BQUOTE))
          keep_byte(CH_BSLASH);
        keep_byte(b);
        pmode = M_DQ;
      end
      M_SQ: begin
        if (b == CH_SQUOTE) pmode = M_WORD;
        else keep_byte(b);
      end
      M_ESC: begin
        keep_byte(b);
        pmode = M_WORD;
      end
      M_TRAIL: begin
        if (!is_ws(b)) begin
          if (is_term(b)) begin
            close_field(b);
            pmode = M_LEAD;
          end else begin
            close_field(CH_SPACE);
            word_char(b);
          end
        end
      end
      default: begin
        pmode = M_LEAD;
        if (!is_ws(b)) word_char(b);
      end
    endcase
    if (eol) begin
      if (pmode == M_DQ_BS || pmode == M_ESC) keep_byte(CH_BSLASH);
      if (pmode != M_LEAD) close_field(CH_SPACE);
      else if (step_n == 0) add_token(KIND_EMPTY, '0, '0, '0);
      pmode = M_LEAD;
      fcount = '0;
    end
    for (int i = 0; i < step_n; i++) begin
      r = step_res[i];
      r.last = (i == step_n - 1);
      token_q.push_back(r);
    end
  endfunction

  function automatic void note_fault(input string msg);
    if (fault_cnt < 10) $display("%s", msg);
    fault_cnt++;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        split_byte(s_axis_tdata, s_axis_tlast);
        n_in <= n_in + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (line_q.size() != 0 && (send_calm || $urandom_range(0, 99) >= 10)) begin
          next_item = line_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= next_item.data;
          s_axis_tlast <= next_item.eol;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_in >= 150) begin
      hold_left <= 200;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (hold_left == 0) && (recv_calm || $urandom_range(0, 99) >= 10);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      n_out <= n_out + 1;
      if (token_q.size() == 0) begin
        note_fault($sformatf("unexpected result: kind %0d tdata %h tlast %b",
                             m_axis_tuser, m_axis_tdata, m_axis_tlast));
      end else begin
        want = token_q.pop_front();
        if (m_axis_tuser !== want.kind || m_axis_tdata[7:0] !== want.out_byte ||
            m_axis_tdata[20:8] !== want.field_length ||
            m_axis_tdata[28:21] !== want.terminator || m_axis_tlast !== want.last) begin
          note_fault({$sformatf("mismatch: expected kind %0d byte %h length %0d term %h last %b,",
                                want.kind, want.out_byte, want.field_length,
                                want.terminator, want.last),
                      $sformatf(" got kind %0d byte %h length %0d term %h last %b",
                                m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[20:8],
                                m_axis_tdata[28:21], m_axis_tlast)});
        end
      end
    end
  end

  function automatic logic [7:0] white_char();
    case ($urandom_range(0, 5))
      0: return 8'h20;
      1: return 8'h09;
      2: return 8'h0a;
      3: return 8'h0b;
      4: return 8'h0c;
      default: return 8'h0d;
    endcase
  endfunction

  function automatic logic [7:0] term_char();
    logic [7:0] c;
    for (int i = 0; i < 64; i++) begin
      c = 8'($urandom_range(0, 255));
      if (is_term(c)) return c;
    end
    return 8'h23;
  endfunction

  function automatic logic [7:0] letter();
    return 8'($urandom_range(8'h61, 8'h7a));
  endfunction

  task automatic flush_line(input logic end_it);
    line_item_t it;
    for (int k = 0; k < line_buf.size(); k++) begin
      it.data = line_buf[k];
      it.eol = end_it && (k == line_buf.size() - 1);
      line_q.push_back(it);
    end
    pushed += line_buf.size();
    line_buf.delete();
  endtask

  task automatic text_line(input string s, input logic end_it);
    for (int k = 0; k < s.len(); k++) line_buf.push_back(s[k]);
    flush_line(end_it);
  endtask

  task automatic add_segment();
    int n;
    logic [7:0] c;
    n = $urandom_range(0, 4);
    case ($urandom_range(0, 4))
      0: repeat (n + 1) line_buf.push_back(letter());
      1: begin
        line_buf.push_back(CH_DQUOTE);
        repeat (n) begin
          if ($urandom_range(0, 2) == 0) begin
            line_buf.push_back(CH_BSLASH);
            case ($urandom_range(0, 4))
              0: c = CH_DQUOTE;
              1: c = CH_DOLLAR;
              2: c = CH_BSLASH;
              3: c = CH_BQUOTE;
              default: c = 8'($urandom_range(0, 255));
            endcase
          end else begin
            c = 8'($urandom_range(0, 255));
            while (c == CH_DQUOTE || c == CH_BSLASH) c = 8'($urandom_range(0, 255));
          end
          line_buf.push_back(c);
        end
        line_buf.push_back(CH_DQUOTE);
      end
      2: begin
        line_buf.push_back(CH_SQUOTE);
        repeat (n) begin
          c = 8'($urandom_range(0, 255));
          while (c == CH_SQUOTE) c = 8'($urandom_range(0, 255));
          line_buf.push_back(c);
        end
        line_buf.push_back(CH_SQUOTE);
      end
      3: begin
        line_buf.push_back(CH_BSLASH);
        line_buf.push_back(8'($urandom_range(0, 255)));
      end
      default: line_buf.push_back(8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic make_line();
    int nw;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) line_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) line_buf.push_back(white_char());
      nw = $urandom_range(0, 3);
      repeat (nw) begin
        repeat ($urandom_range(1, 3)) add_segment();
        case ($urandom_range(0, 3))
          0: repeat ($urandom_range(1, 3)) line_buf.push_back(white_char());
          1: line_buf.push_back(term_char());
          2: begin
            line_buf.push_back(white_char());
            line_buf.push_back(term_char());
            line_buf.push_back(white_char());
          end
          default: ;
        endcase
      end
      if ($urandom_range(0, 6) == 0) begin
        case ($urandom_range(0, 2))
          0: line_buf.push_back(CH_DQUOTE);
          1: line_buf.push_back(CH_SQUOTE);
          default: line_buf.push_back(CH_BSLASH);
        endcase
        if ($urandom_range(0, 1) == 1) line_buf.push_back(letter());
      end
    end
    if (line_buf.size() == 0) line_buf.push_back(white_char());
    flush_line(1'b1);
  endtask

  task automatic random_lines(input int count);
    int goal;
    goal = pushed + count;
    while (pushed < goal) make_line();
  endtask

  task automatic settle();
    while (line_q.size() != 0 || s_axis_tvalid || token_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_TERM_SET_0: term_bits[63:0] = val;
      REG_TERM_SET_1: term_bits[127:64] = val;
      REG_TERM_SET_2: term_bits[191:128] = val;
      REG_TERM_SET_3: term_bits[255:192] = val;
      REG_MAX_FIELD_LEN: cap_reg = val[12:0];
      default: ;
    endcase
  endtask

  task automatic set_terms(input logic [63:0] t0, input logic [63:0] t1,
                           input logic [63:0] t2, input logic [63:0] t3);
    set_reg(REG_TERM_SET_0, t0);
    set_reg(REG_TERM_SET_1, t1);
    set_reg(REG_TERM_SET_2, t2);
    set_reg(REG_TERM_SET_3, t3);
  endtask

  task automatic set_cap(input logic [12:0] len);
    logic [63:0] noise;
    noise = {$urandom, $urandom};
    set_reg(REG_MAX_FIELD_LEN, {noise[63:13], len});
  endtask

  function automatic logic [63:0] sparse_bits();
    return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom} &
           {$urandom, $urandom};
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    text_line(" \t", 1'b1);
    text_line("#", 1'b1);
    text_line("a#", 1'b1);
    text_line("x y", 1'b1);
    line_buf.push_back(8'h00);
    line_buf.push_back(8'hff);
    flush_line(1'b1);
    text_line("\"\\$\\q\"", 1'b1);
    text_line("'b c'", 1'b1);
    text_line("d\\", 1'b1);
    text_line("\"e", 1'b1);
    text_line("f #", 1'b1);
    random_lines(170);
    settle();

    // The double quote bit is forced on, as it must never end a word.
    set_terms(sparse_bits() | (64'd1 << CH_DQUOTE), sparse_bits(), sparse_bits(),
              sparse_bits());
    set_cap(13'($urandom_range(1, 6)));
    for (int k = int'(REG_MAX_FIELD_LEN) + 1; k < (1 << $bits(cfg_index)); k++)
      set_reg(3'(k), {$urandom, $urandom});
    text_line("ab\"c", 1'b0);
    settle();
    text_line("d\" e", 1'b1);
    random_lines(80);
    settle();

    set_terms('0, '0, '0, '0);
    set_cap(13'd0);
    text_line("abc", 1'b1);
    random_lines(50);
    settle();

    set_terms('1, '1, '1, '1);
    set_cap(13'h1fff);
    random_lines(40);
    settle();

    set_terms(TERM_SET_0_RESET, '0, '0, '0);
    repeat (12) line_buf.push_back(8'h61);
    flush_line(1'b1);
    settle();

    set_terms({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom});
    set_cap(13'($urandom_range(2, 40)));
    random_lines(50);
    settle();
    repeat (4) @(posedge clk);

    if (fault_cnt == 0 && token_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("testbench failed");
    $finish;
  end

endmodule
